// ===== hw/rtl/bslpc_pkg.sv =====
`default_nettype none

package bslpc_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_LONG_PRESS_MS = 3'd0,
    REG_MIN_PRESS_MS  = 3'd1,
    REG_LEVEL_HIGH    = 3'd2,
    REG_LEVEL_MID     = 3'd3,
    REG_LEVEL_LOW     = 3'd4,
    REG_MODE_COUNT    = 3'd5
  } reg_index_e;

  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 16;
  localparam int unsigned CfgWidth = 16;

  // register reset values
  localparam logic [15:0] LongPressReset = 16'd800;
  localparam logic [15:0] MinPressReset  = 16'd50;
  localparam logic [7:0]  LevelHighReset = 8'd255;
  localparam logic [7:0]  LevelMidReset  = 8'd70;
  localparam logic [7:0]  LevelLowReset  = 8'd10;
  localparam logic [4:0]  ModeCountReset = 5'd4;

  localparam logic [3:0]  ModeMax = 4'd15;

  // one result word as packed on the output bus, lowest field last
  typedef struct packed {
    logic [1:0] pad;
    logic       mode_stepped;
    logic       brightness_stepped;
    logic [3:0] display_mode;
    logic [7:0] brightness;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/button_short_long_press_control.sv =====
`default_nettype none
// a poll word leaves after it passes the input register and then the result register
// throughput: one poll word per cycle, set by the combinational state update after the
//   input register; back-pressure on the output stalls both registers in place
// reset: asynchronous, active low; clears the press state, brightness to level_high
//   reset value, display mode 0, and the configuration registers to their documented defaults
module button_short_long_press_control (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // poll stream in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [0] button_down, [32:1] now_ms, [39:33] zero
  input  wire logic [bslpc_pkg::InWidth-1:0] s_axis_tdata,
  // result stream out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: [7:0] brightness, [11:8] display_mode, [12] brightness_stepped,
  //        [13] mode_stepped, [15:14] zero
  output logic [bslpc_pkg::OutWidth-1:0]     m_axis_tdata,
  // register write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [bslpc_pkg::CfgWidth-1:0] cfg_data_i
);
  import bslpc_pkg::*;

  // configuration registers
  logic [15:0] long_press_q, min_press_q;
  logic [7:0]  level_high_q, level_mid_q, level_low_q;
  logic [4:0]  mode_count_q;

  // press state
  logic [31:0] press_start_q, press_start_d;
  logic        suppress_q, suppress_d;
  logic [7:0]  level_q, level_d;
  logic [3:0]  mode_q, mode_d;

  // input register
  logic        in_valid_q;
  logic        in_down_q;
  logic [31:0] in_now_q;

  // result register
  logic        out_valid_q;
  out_word_t   out_q, out_d;

  logic        out_free;
  logic        advance;
  logic [15:0] held;
  logic [4:0]  mode_next;
  logic        bstep, mstep;

  // result register can take a word when empty or being drained
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressReset;
      min_press_q  <= MinPressReset;
      level_high_q <= LevelHighReset;
      level_mid_q  <= LevelMidReset;
      level_low_q  <= LevelLowReset;
      mode_count_q <= ModeCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LONG_PRESS_MS: long_press_q <= cfg_data_i;
        REG_MIN_PRESS_MS:  min_press_q  <= cfg_data_i;
        REG_LEVEL_HIGH:    level_high_q <= cfg_data_i[7:0];
        REG_LEVEL_MID:     level_mid_q  <= cfg_data_i[7:0];
        REG_LEVEL_LOW:     level_low_q  <= cfg_data_i[7:0];
        REG_MODE_COUNT:    mode_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_down_q <= s_axis_tdata[0];
      in_now_q  <= s_axis_tdata[32:1];
    end
  end

  // hold time wraps at 16 bits
  assign held      = in_now_q[15:0] - press_start_q[15:0];
  assign mode_next = {1'b0, mode_q} + 5'd1;

  // poll update
  always_comb begin
    press_start_d = press_start_q;
    suppress_d    = suppress_q;
    level_d       = level_q;
    mode_d        = mode_q;
    bstep         = 1'b0;
    mstep         = 1'b0;
    if (in_down_q) begin
      if (press_start_q == '0) begin
        // first held poll; a start at time zero is recorded again next poll
        press_start_d = in_now_q;
      end else if (held > long_press_q) begin
        if (level_q == level_high_q) begin
          level_d = level_low_q;
        end else if (level_q == level_low_q) begin
          level_d = level_mid_q;
        end else begin
          level_d = level_high_q;
        end
        bstep         = 1'b1;
        press_start_d = '0;
        suppress_d    = 1'b1;
      end
    end else if (press_start_q != '0) begin
      if (!suppress_q && held > min_press_q) begin
        // the 4-bit counter wraps after the top mode whatever the count
        if (mode_next >= mode_count_q || mode_next > {1'b0, ModeMax}) begin
          mode_d = '0;
        end else begin
          mode_d = mode_next[3:0];
        end
        mstep = 1'b1;
      end
      press_start_d = '0;
      suppress_d    = 1'b0;
    end
    out_d.pad                = '0;
    out_d.mode_stepped       = mstep;
    out_d.brightness_stepped = bstep;
    out_d.display_mode       = mode_d;
    out_d.brightness         = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_start_q <= '0;
      suppress_q    <= 1'b0;
      level_q       <= LevelHighReset;
      mode_q        <= '0;
    end else if (advance) begin
      press_start_q <= press_start_d;
      suppress_q    <= suppress_d;
      level_q       <= level_d;
      mode_q        <= mode_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bslpc_checker.sv =====
`default_nettype none

module bslpc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [bslpc_pkg::OutWidth-1:0] m_axis_tdata
);
  import bslpc_pkg::*;

  out_word_t  word;
  logic       seen_q;
  logic [7:0] last_level_q;
  logic [3:0] last_mode_q;
  logic       out_acc;

  assign word    = m_axis_tdata;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_level_q <= LevelHighReset;
      last_mode_q  <= '0;
    end else if (out_acc) begin
      seen_q       <= 1'b1;
      last_level_q <= word.brightness;
      last_mode_q  <= word.display_mode;
    end
  end

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed under back-pressure");

  // a poll is either a hold or a release, never both steps
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(word.brightness_stepped && word.mode_stepped))
    else $error("brightness and mode stepped on the same poll");

  // brightness only moves on a step
  a_level_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && !word.brightness_stepped |-> word.brightness == last_level_q)
    else $error("brightness changed without a step");

  // mode only moves on an advance
  a_mode_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !word.mode_stepped |-> word.display_mode == last_mode_q)
    else $error("display mode changed without an advance");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> word.pad == '0)
    else $error("result padding not zero");

endmodule

bind button_short_long_press_control bslpc_checker u_bslpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
